>>> hw/rtl/cdrd_pkg.sv
package cdrd_pkg;

  // depth store size and derived widths
  localparam int MAX_POSITIONS = 1048576;
  localparam int ADDR_W        = $clog2(MAX_POSITIONS);
  localparam int LEN_W         = ADDR_W + 1;

  // fixed field widths
  localparam int FIELD_W = 21;
  localparam int START_W = 20;
  localparam int TRIM_W  = 16;
  localparam int DEPTH_W = 8;

  // working width for length compares, one more bit for signed span math
  localparam int WIDE_W = (LEN_W > FIELD_W) ? LEN_W : FIELD_W;
  localparam int LAST_W = WIDE_W + 1;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_TRIM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH   = 2'd2;

  // request codes
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_SCAN = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_PREP,
    ST_ADD_SET,
    ST_ADD_RUN,
    ST_ADD_DRAIN,
    ST_SCAN_RD,
    ST_SCAN_EVAL
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic add_prep;
    logic add_set;
    logic add_step;
    logic scan_read;
    logic scan_commit;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic add_go;
    logic walk_last;
    logic emit_req;
    logic out_busy;
  } sts_t;

endpackage

>>> hw/rtl/cdrd_ctrl.sv
module cdrd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_req_type,
  output logic          in_ready,
  input  cdrd_pkg::sts_t sts,
  output cdrd_pkg::cmd_t cmd
);
  import cdrd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_req_type == REQ_SCAN) ? ST_SCAN_RD : ST_ADD_PREP;
        end
      end
      ST_ADD_PREP: begin
        cmd.add_prep = 1'b1;
        state_nxt    = ST_ADD_SET;
      end
      ST_ADD_SET: begin
        cmd.add_set = 1'b1;
        state_nxt   = ST_ADD_RUN;
      end
      ST_ADD_RUN: begin
        if (!sts.add_go) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.add_step = 1'b1;
          if (sts.walk_last) begin
            state_nxt = ST_ADD_DRAIN;
          end
        end
      end
      ST_ADD_DRAIN: begin
        // last pending write lands here
        state_nxt = ST_IDLE;
      end
      ST_SCAN_RD: begin
        cmd.scan_read = 1'b1;
        state_nxt     = ST_SCAN_EVAL;
      end
      ST_SCAN_EVAL: begin
        if (!(sts.emit_req && sts.out_busy)) begin
          cmd.scan_commit = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/cdrd_dp.sv
module cdrd_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cdrd_pkg::cmd_t                     cmd,
  output cdrd_pkg::sts_t                     sts,
  input  logic                               cfg_wr_en,
  input  logic [cdrd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cdrd_pkg::FIELD_W-1:0]       cfg_data,
  input  logic                               in_read_mapped,
  input  logic [cdrd_pkg::START_W-1:0]       in_read_start,
  input  logic [cdrd_pkg::FIELD_W-1:0]       in_read_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cdrd_pkg::FIELD_W-1:0]       out_run_begin,
  output logic [cdrd_pkg::FIELD_W-1:0]       out_run_finish,
  output logic [cdrd_pkg::FIELD_W-1:0]       out_run_length
);
  import cdrd_pkg::*;

  // configuration
  logic [TRIM_W-1:0]  trim_r;
  logic [DEPTH_W-1:0] min_depth_r;
  logic [FIELD_W-1:0] seq_len_r;
  logic [FIELD_W-1:0] seq_len_sel;
  logic [LEN_W-1:0]   len_eff_r;
  logic [LEN_W-1:0]   len_eff_nxt;
  logic [WIDE_W-1:0]  len_w;
  logic [WIDE_W-1:0]  lenm1_w;

  // add item
  logic                     mapped_r;
  logic [START_W-1:0]       start_r;
  logic [FIELD_W-1:0]       end_r;
  logic signed [LAST_W-1:0] last_r;
  logic signed [LAST_W-1:0] start_s;
  logic signed [LAST_W-1:0] lenm1_s;
  logic                     ok_r;
  logic                     go_r;
  logic [ADDR_W-1:0]        hi_r;
  logic [ADDR_W-1:0]        walk_r;
  logic                     pend_r;
  logic [ADDR_W-1:0]        pend_addr_r;
  logic [ADDR_W-1:0]        clr_addr_r;

  // scan state
  logic              in_run_r;
  logic [ADDR_W-1:0] open_start_r;
  logic [ADDR_W-1:0] pos_r;
  logic              wrap;
  logic              hit;
  logic              at_end;
  logic              close_run;
  logic              end_run;
  logic [ADDR_W-1:0] first0;
  logic [WIDE_W-1:0] finish_w;
  logic [WIDE_W-1:0] begin_w;
  logic [WIDE_W-1:0] length_w;

  // depth store
  logic [DEPTH_W-1:0] depth_mem [MAX_POSITIONS];
  logic [DEPTH_W-1:0] rdata_r;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [DEPTH_W-1:0] mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;

  // output register
  logic               out_valid_r;
  logic [FIELD_W-1:0] out_begin_r;
  logic [FIELD_W-1:0] out_finish_r;
  logic [FIELD_W-1:0] out_length_r;

  // length being written this cycle takes effect with the register itself
  assign seq_len_sel = (cfg_wr_en && (cfg_index == REG_SEQ_LENGTH)) ? cfg_data : seq_len_r;

  // effective length: clamp to store size, zero counts as one
  always_comb begin
    if (seq_len_sel == '0) begin
      len_eff_nxt = LEN_W'(1);
    end else if (WIDE_W'(seq_len_sel) > WIDE_W'(MAX_POSITIONS)) begin
      len_eff_nxt = LEN_W'(MAX_POSITIONS);
    end else begin
      len_eff_nxt = LEN_W'(seq_len_sel);
    end
  end

  assign len_w   = WIDE_W'(len_eff_r);
  assign lenm1_w = len_w - WIDE_W'(1);
  assign start_s = $signed(LAST_W'(start_r));
  assign lenm1_s = $signed(LAST_W'(lenm1_w));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_r      <= '0;
      min_depth_r <= DEPTH_W'(1);
      seq_len_r   <= FIELD_W'(1048576);
      len_eff_r   <= LEN_W'(MAX_POSITIONS);
    end else begin
      len_eff_r <= len_eff_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_OVERLAP_TRIM: trim_r      <= cfg_data[TRIM_W-1:0];
          REG_MIN_DEPTH:    min_depth_r <= cfg_data[DEPTH_W-1:0];
          REG_SEQ_LENGTH:   seq_len_r   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // item capture and span setup
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mapped_r <= in_read_mapped;
      start_r  <= in_read_start;
      end_r    <= in_read_end;
    end
    if (cmd.add_prep) begin
      last_r <= $signed(LAST_W'(end_r)) - $signed(LAST_W'(trim_r));
      ok_r   <= mapped_r && (WIDE_W'(start_r) < WIDE_W'(end_r))
                && (WIDE_W'(start_r) < len_w);
    end
    if (cmd.add_set) begin
      go_r <= ok_r && (last_r >= start_s);
      hi_r <= (last_r > lenm1_s) ? lenm1_w[ADDR_W-1:0] : last_r[ADDR_W-1:0];
    end
  end

  // walk pointer, pending write-back and clear sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      pend_r <= cmd.add_step;
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_set) begin
      walk_r <= ADDR_W'(start_r);
    end else if (cmd.add_step) begin
      walk_r <= walk_r + ADDR_W'(1);
    end
    if (cmd.add_step) begin
      pend_addr_r <= walk_r;
    end
  end

  // memory port control
  always_comb begin
    mem_we    = cmd.clr_step | pend_r;
    mem_waddr = cmd.clr_step ? clr_addr_r : pend_addr_r;
    if (cmd.clr_step) begin
      mem_wdata = '0;
    end else if (rdata_r == DEPTH_MAX) begin
      mem_wdata = DEPTH_MAX;
    end else begin
      mem_wdata = rdata_r + DEPTH_W'(1);
    end
    mem_re    = cmd.add_step | cmd.scan_read;
    if (cmd.scan_read) begin
      mem_raddr = wrap ? '0 : pos_r;
    end else begin
      mem_raddr = walk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      depth_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= depth_mem[mem_raddr];
    end
  end

  // scan evaluation
  always_comb begin
    wrap      = WIDE_W'(pos_r) >= len_w;
    hit       = rdata_r >= min_depth_r;
    at_end    = WIDE_W'(pos_r) == lenm1_w;
    close_run = !hit && in_run_r;
    end_run   = hit && at_end;
    first0    = in_run_r ? open_start_r : pos_r;
    finish_w  = close_run ? WIDE_W'(pos_r) : len_w;
    begin_w   = WIDE_W'(first0) + WIDE_W'(1);
    length_w  = finish_w - WIDE_W'(first0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r     <= 1'b0;
      open_start_r <= '0;
      pos_r        <= '0;
    end else if (cmd.scan_read) begin
      // pointer past a shortened sequence wraps and drops the open run
      if (wrap) begin
        pos_r    <= '0;
        in_run_r <= 1'b0;
      end
    end else if (cmd.scan_commit) begin
      if (hit && !in_run_r) begin
        open_start_r <= pos_r;
      end
      in_run_r <= hit && !at_end;
      pos_r    <= at_end ? '0 : pos_r + ADDR_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.scan_commit && (close_run || end_run)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_commit && (close_run || end_run)) begin
      out_begin_r  <= begin_w[FIELD_W-1:0];
      out_finish_r <= finish_w[FIELD_W-1:0];
      out_length_r <= length_w[FIELD_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_run_begin  = out_begin_r;
  assign out_run_finish = out_finish_r;
  assign out_run_length = out_length_r;

  // status to controller
  assign sts.clr_done  = clr_addr_r == ADDR_W'(MAX_POSITIONS - 1);
  assign sts.add_go    = go_r;
  assign sts.walk_last = walk_r == hi_r;
  assign sts.emit_req  = close_run || end_run;
  assign sts.out_busy  = out_valid_r && !out_ready;

endmodule

>>> hw/rtl/coverage_depth_run_detector.sv
// Per-position read depth store with run reporting. After reset the block
// zeroes its depth memory, one position per cycle, before in_ready first
// rises; configuration writes are taken during that sweep. An add transfer
// updates each position the read covers after trimming and clipping: the
// depth memory, with one read port and one write port, is walked with one
// read-increment-write per cycle, pipelined behind its registered read. A
// scan transfer reads the depth at the scan pointer, then compares and
// commits; it holds at commit while it would report a run and a previous
// run still sits unaccepted on the output.
// Runs are reported with 1-based inclusive begin and finish plus length.
module coverage_depth_run_detector (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [cdrd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cdrd_pkg::FIELD_W-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic                           in_read_mapped,
  input  logic [cdrd_pkg::START_W-1:0]   in_read_start,
  input  logic [cdrd_pkg::FIELD_W-1:0]   in_read_end,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cdrd_pkg::FIELD_W-1:0]   out_run_begin,
  output logic [cdrd_pkg::FIELD_W-1:0]   out_run_finish,
  output logic [cdrd_pkg::FIELD_W-1:0]   out_run_length
);
  import cdrd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  cdrd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // depth memory, span and scan logic
  cdrd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_read_mapped (in_read_mapped),
    .in_read_start  (in_read_start),
    .in_read_end    (in_read_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_run_begin  (out_run_begin),
    .out_run_finish (out_run_finish),
    .out_run_length (out_run_length)
  );

endmodule

>>> hw/rtl/cdrd_checker.sv
module cdrd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_req_type,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [cdrd_pkg::FIELD_W-1:0] out_run_begin,
  input logic [cdrd_pkg::FIELD_W-1:0] out_run_finish,
  input logic [cdrd_pkg::FIELD_W-1:0] out_run_length
);
  import cdrd_pkg::*;

  // a stalled run report keeps its contents
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_run_begin)
      && $stable(out_run_finish) && $stable(out_run_length))
    else $error("run report changed while stalled");

  // length agrees with begin and finish
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run_length
      == FIELD_W'(out_run_finish - out_run_begin + FIELD_W'(1)))
    else $error("run length inconsistent with bounds");

  // once ready, the block only leaves idle through a transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && !in_valid |=> in_ready)
    else $error("input ready dropped without a transfer");

  // an add transfer never raises a report
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_ADD) && !out_valid |=> !out_valid)
    else $error("report raised by an add transfer");

endmodule

bind coverage_depth_run_detector cdrd_checker u_cdrd_checker (.*);
